>>> rtl/sliding_window_rgb_box_sum_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB box sum block
// Two forms: a same-cycle implication and a next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RGB_BOX_SUM_ASSERT_SVH
`define SLIDING_WINDOW_RGB_BOX_SUM_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SWBS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swbs assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define SWBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swbs assertion failed");

`endif

>>> rtl/swbs_pkg.sv
// ----------------------------------------------------------------------------
// swbs_pkg
// Shared types and constants of the RGB box sum block.
// ----------------------------------------------------------------------------
package swbs_pkg;

  localparam int PIX_W     = 24;
  localparam int SUM_W     = 20;
  localparam int POS_W     = 11;
  localparam int CFG_W     = 12;
  localparam int IDX_W     = 3;
  localparam int WIN_W     = 7;
  localparam int ROW_LIMIT = 2048;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALIGNED_ONLY  = 3'd4;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } rgb_sum_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first_col;
    logic             sub_col;
    logic             first_row;
    logic             sub_row;
    logic             report;
    logic [POS_W-1:0] wx;
    logic [POS_W-1:0] wy;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] wx;
    logic [POS_W-1:0] wy;
    rgb_sum_t         sums;
  } result_t;

endpackage

>>> rtl/swbs_ram.sv
// ----------------------------------------------------------------------------
// swbs_ram
// Generic single write, single read RAM with registered read (read first).
// ----------------------------------------------------------------------------
module swbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/swbs_fifo.sv
// ----------------------------------------------------------------------------
// swbs_fifo
// Small register queue with count, used between front and back and at output.
// ----------------------------------------------------------------------------
module swbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full,
  output logic [CNW-1:0]   count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  assign empty = (count == '0);
  assign full  = (count == CNW'(DEPTH));
  assign rdata = slots[rptr];

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + CNW'(wr) - CNW'(rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/swbs_front.sv
// ----------------------------------------------------------------------------
// swbs_front
// Holds registers and position, classifies each pixel into a back command.
// ----------------------------------------------------------------------------
module swbs_front #(
  parameter int MAXW = 2048,
  parameter int MWH  = 64,
  parameter int MWW  = 64,
  localparam int CW  = $clog2(MAXW),
  localparam int AW  = (MWH * MAXW > 1) ? $clog2(MWH * MAXW) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [swbs_pkg::PIX_W-1:0]  pixel,
  input  logic                        frame_start,
  input  logic                        cfg_valid,
  input  logic [swbs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [swbs_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        clearing,
  input  logic                        cmd_full,
  output logic                        full,
  output logic                        cmd_push,
  output swbs_pkg::cmd_t              cmd,
  output logic [CW-1:0]               cmd_col,
  output logic [CW-1:0]               cmd_cww,
  output logic [AW-1:0]               cmd_wr_addr,
  output logic [AW-1:0]               cmd_rd_addr
);

  localparam int IWW = $clog2(MAXW + 1);
  localparam int XW  = (IWW > 12) ? IWW : 12;
  localparam int CXW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int SW  = (MWH > 1) ? $clog2(MWH) : 1;
  localparam int PB  = (CW > swbs_pkg::POS_W) ? CW : swbs_pkg::POS_W;
  localparam int PCW = $clog2(PB + 1);

  // registers
  logic [11:0] iw_reg, ih_reg;
  logic [6:0]  ww_reg, wh_reg;
  logic        al_reg;
  logic [CW-1:0] col, col_next;
  logic [10:0]   row, row_next;
  logic [6:0]    cm, cm_next, rm, rm_next;
  logic [SW-1:0] rs, rs_next;
  // remainder recompute after a register write
  logic [PCW-1:0] rc_cnt;
  logic [PB-1:0]  dcol, drow;
  logic [6:0]     remc, remr, remc_next, remr_next;
  logic [7:0]     tc, tr;

  // effective sizes
  logic [XW-1:0]  iw_x;
  logic [IWW-1:0] iw;
  logic [11:0]    ih;
  logic [6:0]     ww, wh;

  logic          accept, busy, cfg_wr;
  logic [CW-1:0] c;
  logic [11:0]   r, r1;
  logic [6:0]    cmc, rmr;
  logic [SW-1:0] rsr;
  logic [CXW-1:0] c1, wxf;
  logic [11:0]   wyf;
  logic [9:0]    rs10, old10;
  logic          al_ok;

  always_comb begin
    iw_x = (iw_reg == '0) ? XW'(1) : ((XW'(iw_reg) > XW'(MAXW)) ? XW'(MAXW) : XW'(iw_reg));
    iw   = IWW'(iw_x);
    ih   = (ih_reg == '0) ? 12'd1 :
           ((ih_reg > 12'(swbs_pkg::ROW_LIMIT)) ? 12'(swbs_pkg::ROW_LIMIT) : ih_reg);
    ww   = (ww_reg == '0) ? 7'd1 : ((9'(ww_reg) > 9'(MWW)) ? 7'(MWW) : ww_reg);
    wh   = (wh_reg == '0) ? 7'd1 : ((9'(wh_reg) > 9'(MWH)) ? 7'(MWH) : wh_reg);
  end

  assign busy     = (rc_cnt != '0);
  assign full     = cmd_full | busy | clearing;
  assign accept   = push & ~full;
  assign cmd_push = accept;
  assign cfg_wr   = cfg_valid;

  // position of this pixel, with frame start and wrap
  always_comb begin
    c   = col;
    r   = 12'(row);
    cmc = cm;
    rmr = rm;
    rsr = rs;
    if (frame_start) begin
      c   = '0;
      r   = '0;
      cmc = '0;
      rmr = '0;
      rsr = '0;
    end else if (IWW'(col) >= iw) begin
      c   = '0;
      cmc = '0;
      r   = 12'(row) + 12'd1;
      rmr = (8'(rm) + 8'd1 == 8'(wh)) ? '0 : rm + 7'd1;
      rsr = (rs == SW'(MWH - 1)) ? '0 : rs + SW'(1);
    end
    if (r >= ih) begin
      r   = '0;
      rmr = '0;
      rsr = '0;
    end
  end

  // classification
  always_comb begin
    c1    = CXW'(c) + CXW'(1);
    wxf   = c1 - CXW'(ww);
    r1    = r + 12'd1;
    wyf   = r1 - 12'(wh);
    al_ok = ~al_reg | ((cmc == ww - 7'd1) & (rmr == wh - 7'd1));
    rs10  = 10'(rsr);
    old10 = (rs10 >= 10'(wh)) ? rs10 - 10'(wh) : rs10 + 10'(MWH) - 10'(wh);

    cmd.pixel     = pixel;
    cmd.first_col = (c == '0);
    cmd.sub_col   = (CXW'(c) >= CXW'(ww));
    cmd.first_row = (r == '0);
    cmd.sub_row   = (r >= 12'(wh));
    cmd.report    = (c1 >= CXW'(ww)) & (r1 >= 12'(wh)) & al_ok;
    cmd.wx        = wxf[swbs_pkg::POS_W-1:0];
    cmd.wy        = wyf[swbs_pkg::POS_W-1:0];
    cmd_col       = c;
    cmd_cww       = CW'(CXW'(c) - CXW'(ww));
    cmd_wr_addr   = AW'(rsr) * AW'(MAXW) + AW'(c);
    cmd_rd_addr   = AW'(old10) * AW'(MAXW) + AW'(c);
  end

  // position after this pixel
  always_comb begin
    col_next = col;
    row_next = row;
    cm_next  = cm;
    rm_next  = rm;
    rs_next  = rs;
    if (accept) begin
      if (c1 >= CXW'(iw)) begin
        col_next = '0;
        cm_next  = '0;
        if (r1 >= ih) begin
          row_next = '0;
          rm_next  = '0;
          rs_next  = '0;
        end else begin
          row_next = r1[10:0];
          rm_next  = (8'(rmr) + 8'd1 == 8'(wh)) ? '0 : rmr + 7'd1;
          rs_next  = (rsr == SW'(MWH - 1)) ? '0 : rsr + SW'(1);
        end
      end else begin
        col_next = CW'(c1);
        cm_next  = (8'(cmc) + 8'd1 == 8'(ww)) ? '0 : cmc + 7'd1;
        row_next = r[10:0];
        rm_next  = rmr;
        rs_next  = rsr;
      end
    end else if (busy && rc_cnt == PCW'(1)) begin
      cm_next = remc_next;
      rm_next = remr_next;
    end
  end

  // one restoring remainder step per cycle for column and row
  always_comb begin
    tc        = {remc, dcol[PB-1]};
    tr        = {remr, drow[PB-1]};
    remc_next = (tc >= {1'b0, ww}) ? 7'(tc - {1'b0, ww}) : tc[6:0];
    remr_next = (tr >= {1'b0, wh}) ? 7'(tr - {1'b0, wh}) : tr[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iw_reg <= 12'd2048;
      ih_reg <= 12'd2048;
      ww_reg <= 7'd8;
      wh_reg <= 7'd8;
      al_reg <= 1'b0;
      col    <= '0;
      row    <= '0;
      cm     <= '0;
      rm     <= '0;
      rs     <= '0;
      rc_cnt <= '0;
      dcol   <= '0;
      drow   <= '0;
      remc   <= '0;
      remr   <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      cm  <= cm_next;
      rm  <= rm_next;
      rs  <= rs_next;
      if (cfg_wr) begin
        unique case (cfg_index)
          swbs_pkg::REG_IMAGE_WIDTH:   iw_reg <= cfg_data;
          swbs_pkg::REG_IMAGE_HEIGHT:  ih_reg <= cfg_data;
          swbs_pkg::REG_WINDOW_WIDTH:  ww_reg <= cfg_data[6:0];
          swbs_pkg::REG_WINDOW_HEIGHT: wh_reg <= cfg_data[6:0];
          swbs_pkg::REG_ALIGNED_ONLY:  al_reg <= cfg_data[0];
          default: ;
        endcase
        // restart the remainder of the stored position
        rc_cnt <= PCW'(PB);
        dcol   <= PB'(col);
        drow   <= PB'(row);
        remc   <= '0;
        remr   <= '0;
      end else if (busy) begin
        rc_cnt <= rc_cnt - PCW'(1);
        dcol   <= dcol << 1;
        drow   <= drow << 1;
        remc   <= remc_next;
        remr   <= remr_next;
      end
    end
  end

endmodule

>>> rtl/swbs_back.sv
// ----------------------------------------------------------------------------
// swbs_back
// Three stage pipeline: row store and column sum reads, column update,
// horizontal running sum. Clears the column sums after reset.
// ----------------------------------------------------------------------------
`include "sliding_window_rgb_box_sum_assert.svh"

module swbs_back #(
  parameter int MAXW = 2048,
  parameter int MWH  = 64,
  localparam int CW  = $clog2(MAXW),
  localparam int AW  = (MWH * MAXW > 1) ? $clog2(MWH * MAXW) : 1,
  localparam int OCW = $clog2(swbs_pkg::OUT_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  swbs_pkg::cmd_t     cmd,
  input  logic [CW-1:0]      cmd_col,
  input  logic [CW-1:0]      cmd_cww,
  input  logic [AW-1:0]      cmd_wr_addr,
  input  logic [AW-1:0]      cmd_rd_addr,
  input  logic [OCW-1:0]     out_count,
  output logic               cmd_pop,
  output logic               clearing,
  output logic               out_push,
  output swbs_pkg::result_t  out_data
);

  localparam int SUMS_W = 3 * swbs_pkg::SUM_W;

  logic          issue;
  logic [CW-1:0] clr_cnt;

  // stage 1
  logic              v1;
  swbs_pkg::cmd_t    cmd1;
  logic [CW-1:0]     col1, cww1;
  logic [swbs_pkg::PIX_W-1:0] old_pix;
  swbs_pkg::rgb_sum_t ram_a, ram_b, col_c, col_w, ncs;
  logic [swbs_pkg::SUM_W-1:0] sub_r, sub_g, sub_b;
  // previous cycle write, for forwarding
  logic               pw_v;
  logic [CW-1:0]      pw_a;
  swbs_pkg::rgb_sum_t pw_d;
  // column sum write
  logic               cs_we;
  logic [CW-1:0]      cs_wa;
  swbs_pkg::rgb_sum_t cs_wd;

  // stage 2
  logic               v2;
  swbs_pkg::cmd_t     cmd2;
  swbs_pkg::rgb_sum_t ncs2, cww2, h, h_next;

  // issue only with room for every result in flight
  assign issue   = ~cmd_empty & ~clearing &
                   ((4'(out_count) + 4'(v1) + 4'(v2)) < 4'(swbs_pkg::OUT_DEPTH));
  assign cmd_pop = issue;

  swbs_ram #(.WIDTH(swbs_pkg::PIX_W), .DEPTH(MWH * MAXW)) u_store (
    .clk   (clk),
    .we    (issue),
    .waddr (cmd_wr_addr),
    .wdata (cmd.pixel),
    .raddr (cmd_rd_addr),
    .rdata (old_pix)
  );

  swbs_ram #(.WIDTH(SUMS_W), .DEPTH(MAXW)) u_col_a (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_wa),
    .wdata (cs_wd),
    .raddr (cmd_col),
    .rdata (ram_a)
  );

  swbs_ram #(.WIDTH(SUMS_W), .DEPTH(MAXW)) u_col_b (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_wa),
    .wdata (cs_wd),
    .raddr (cmd_cww),
    .rdata (ram_b)
  );

  // column update with forwarding of last cycle's write
  always_comb begin
    col_c = (pw_v && pw_a == col1) ? pw_d : ram_a;
    col_w = (pw_v && pw_a == cww1) ? pw_d : ram_b;
    sub_r = cmd1.sub_row ? swbs_pkg::SUM_W'(old_pix[7:0])   : '0;
    sub_g = cmd1.sub_row ? swbs_pkg::SUM_W'(old_pix[15:8])  : '0;
    sub_b = cmd1.sub_row ? swbs_pkg::SUM_W'(old_pix[23:16]) : '0;
    if (cmd1.first_row) begin
      ncs.red   = swbs_pkg::SUM_W'(cmd1.pixel[7:0]);
      ncs.green = swbs_pkg::SUM_W'(cmd1.pixel[15:8]);
      ncs.blue  = swbs_pkg::SUM_W'(cmd1.pixel[23:16]);
    end else begin
      ncs.red   = col_c.red   + swbs_pkg::SUM_W'(cmd1.pixel[7:0])   - sub_r;
      ncs.green = col_c.green + swbs_pkg::SUM_W'(cmd1.pixel[15:8])  - sub_g;
      ncs.blue  = col_c.blue  + swbs_pkg::SUM_W'(cmd1.pixel[23:16]) - sub_b;
    end
    cs_we = clearing | v1;
    cs_wa = clearing ? clr_cnt : col1;
    cs_wd = clearing ? '0 : ncs;
  end

  // horizontal running sum
  always_comb begin
    if (cmd2.first_col) begin
      h_next = ncs2;
    end else if (cmd2.sub_col) begin
      h_next.red   = h.red   + ncs2.red   - cww2.red;
      h_next.green = h.green + ncs2.green - cww2.green;
      h_next.blue  = h.blue  + ncs2.blue  - cww2.blue;
    end else begin
      h_next.red   = h.red   + ncs2.red;
      h_next.green = h.green + ncs2.green;
      h_next.blue  = h.blue  + ncs2.blue;
    end
    out_push      = v2 & cmd2.report;
    out_data.wx   = cmd2.wx;
    out_data.wy   = cmd2.wy;
    out_data.sums = h_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      pw_v     <= 1'b0;
      h        <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + CW'(1);
        if (clr_cnt == CW'(MAXW - 1)) begin
          clearing <= 1'b0;
        end
      end
      v1   <= issue;
      v2   <= v1;
      pw_v <= v1;
      if (v2) begin
        h <= h_next;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    cmd1 <= cmd;
    col1 <= cmd_col;
    cww1 <= cmd_cww;
    pw_a <= col1;
    pw_d <= ncs;
    cmd2 <= cmd1;
    ncs2 <= ncs;
    cww2 <= col_w;
  end

  `SWBS_ASSERT_SAME(a_no_issue_in_clear, clk, rst, clearing, !issue)
  `SWBS_ASSERT_NEXT(a_pipe_no_stall, clk, rst, v1, v2)
  `SWBS_ASSERT_SAME(a_clear_ends_empty, clk, rst, $fell(clearing), !v1 && !v2)

endmodule

>>> rtl/sliding_window_rgb_box_sum.sv
// ----------------------------------------------------------------------------
// sliding_window_rgb_box_sum
// Streaming RGB box sum over every fully covered (or every aligned) frame window.
//
// Pixels (0x00BBGGRR) enter through push/full, one per cycle at most; set
// frame_start on the first pixel of a frame. Results leave through empty/pop:
// the oldest result sits on win_x, win_y and the three sums while empty is low.
// A result belongs to the pixel that completes a window's bottom-right corner
// and reaches the result ports through the command queue, the back end stages
// and the result queue. Throughput is one pixel per cycle while full is low;
// the front classifies a pixel, a four entry queue feeds the three stage back
// end (row store read, column sum update, horizontal sum). If the receiver
// stalls, results gather in a four entry output queue and the back end holds
// issue; full then rises once the command queue fills.
// Registers are written over cfg_valid/cfg_ready (always ready); the user must
// write them only while idle, which the block does not enforce. A write makes
// full high while the position remainders are recomputed.
// After reset all MAX_IMAGE_WIDTH column sums are cleared, during which full
// is high.
// ----------------------------------------------------------------------------
`include "sliding_window_rgb_box_sum_assert.svh"

module sliding_window_rgb_box_sum #(
  parameter int MAX_IMAGE_WIDTH   = 2048,
  parameter int MAX_WINDOW_HEIGHT = 64,
  parameter int MAX_WINDOW_WIDTH  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [swbs_pkg::PIX_W-1:0]  pixel,
  input  logic                        frame_start,
  output logic                        empty,
  input  logic                        pop,
  output logic [swbs_pkg::POS_W-1:0]  win_x,
  output logic [swbs_pkg::POS_W-1:0]  win_y,
  output logic [swbs_pkg::SUM_W-1:0]  red_sum,
  output logic [swbs_pkg::SUM_W-1:0]  green_sum,
  output logic [swbs_pkg::SUM_W-1:0]  blue_sum,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swbs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [swbs_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_IMAGE_WIDTH);
  localparam int AW  = (MAX_WINDOW_HEIGHT * MAX_IMAGE_WIDTH > 1) ?
                       $clog2(MAX_WINDOW_HEIGHT * MAX_IMAGE_WIDTH) : 1;
  localparam int QW  = $bits(swbs_pkg::cmd_t) + 2 * CW + 2 * AW;
  localparam int CCW = $clog2(swbs_pkg::CMD_DEPTH + 1);
  localparam int OCW = $clog2(swbs_pkg::OUT_DEPTH + 1);

  logic              clearing, cmd_full, cmd_empty, cmd_push, cmd_pop;
  logic [CCW-1:0]    cmd_count;
  swbs_pkg::cmd_t    f_cmd, b_cmd;
  logic [CW-1:0]     f_col, f_cww, b_col, b_cww;
  logic [AW-1:0]     f_wa, f_ra, b_wa, b_ra;
  logic              out_push, out_full;
  logic [OCW-1:0]    out_count;
  swbs_pkg::result_t res_in, res_out;

  assign cfg_ready = 1'b1;

  swbs_front #(
    .MAXW (MAX_IMAGE_WIDTH),
    .MWH  (MAX_WINDOW_HEIGHT),
    .MWW  (MAX_WINDOW_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pixel       (pixel),
    .frame_start (frame_start),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .clearing    (clearing),
    .cmd_full    (cmd_full),
    .full        (full),
    .cmd_push    (cmd_push),
    .cmd         (f_cmd),
    .cmd_col     (f_col),
    .cmd_cww     (f_cww),
    .cmd_wr_addr (f_wa),
    .cmd_rd_addr (f_ra)
  );

  // command queue between front and back
  swbs_fifo #(.WIDTH(QW), .DEPTH(swbs_pkg::CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata ({f_cmd, f_col, f_cww, f_wa, f_ra}),
    .rd    (cmd_pop),
    .rdata ({b_cmd, b_col, b_cww, b_wa, b_ra}),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  swbs_back #(
    .MAXW (MAX_IMAGE_WIDTH),
    .MWH  (MAX_WINDOW_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd         (b_cmd),
    .cmd_col     (b_col),
    .cmd_cww     (b_cww),
    .cmd_wr_addr (b_wa),
    .cmd_rd_addr (b_ra),
    .out_count   (out_count),
    .cmd_pop     (cmd_pop),
    .clearing    (clearing),
    .out_push    (out_push),
    .out_data    (res_in)
  );

  // result queue
  swbs_fifo #(.WIDTH($bits(swbs_pkg::result_t)), .DEPTH(swbs_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (res_in),
    .rd    (pop & ~empty),
    .rdata (res_out),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign win_x     = res_out.wx;
  assign win_y     = res_out.wy;
  assign red_sum   = res_out.sums.red;
  assign green_sum = res_out.sums.green;
  assign blue_sum  = res_out.sums.blue;

  `SWBS_ASSERT_SAME(a_out_no_overflow, clk, rst, out_push, !out_full || pop)
  `SWBS_ASSERT_SAME(a_cmd_no_overflow, clk, rst, cmd_push, !cmd_full)
  `SWBS_ASSERT_SAME(a_cmd_count_ok, clk, rst, cmd_pop, cmd_count != '0)

endmodule

>>> tb/sliding_window_rgb_box_sum_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_rgb_box_sum_tb
// Self-checking bench for the streaming RGB box sum. A directed table covers
// pixel extremes and frame restarts. Directed size phases and random frames
// over many image and window sizes follow, with out-of-range register values
// and aligned mode. Results are scored against an in-bench model or typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_rgb_box_sum_tb;

  localparam int STORE_W  = 2048;
  localparam int STORE_H  = 64;
  localparam int SETTLE   = 30;

  logic                       clk;
  logic                       rst;
  logic                       push;
  logic                       full;
  logic [swbs_pkg::PIX_W-1:0] pixel;
  logic                       frame_start;
  logic                       empty;
  logic                       pop;
  logic [swbs_pkg::POS_W-1:0] win_x;
  logic [swbs_pkg::POS_W-1:0] win_y;
  logic [swbs_pkg::SUM_W-1:0] red_sum;
  logic [swbs_pkg::SUM_W-1:0] green_sum;
  logic [swbs_pkg::SUM_W-1:0] blue_sum;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [swbs_pkg::IDX_W-1:0] cfg_index;
  logic [swbs_pkg::CFG_W-1:0] cfg_data;

  sliding_window_rgb_box_sum dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel(pixel),
    .frame_start(frame_start), .empty(empty), .pop(pop), .win_x(win_x),
    .win_y(win_y), .red_sum(red_sum), .green_sum(green_sum),
    .blue_sum(blue_sum), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // window sums still owed by the block, oldest first
  swbs_pkg::result_t window_q[$];
  int      err_count;
  int      random_pixels;
  bit      tx_eager;
  bit      rx_eager;

  // model state
  logic [swbs_pkg::PIX_W-1:0] rows_m [0:STORE_W*STORE_H-1];
  logic [swbs_pkg::SUM_W-1:0] col_m  [0:STORE_W-1][0:2];
  logic [swbs_pkg::SUM_W-1:0] horz_m [0:2];
  int                         col_pos;
  int                         row_pos;
  logic [swbs_pkg::CFG_W-1:0] img_w_reg;
  logic [swbs_pkg::CFG_W-1:0] img_h_reg;
  logic [swbs_pkg::WIN_W-1:0] win_w_reg;
  logic [swbs_pkg::WIN_W-1:0] win_h_reg;
  logic                       align_reg;

  // directed table row
  typedef struct {
    logic [swbs_pkg::PIX_W-1:0] px;
    bit                         fs;
    bit                         typed;
    swbs_pkg::result_t          want;
  } stim_row_t;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp_to(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // box sum model: one pixel in, at most one window out
  task automatic box_sum_step(input logic [swbs_pkg::PIX_W-1:0] px, input bit fs,
                              output bit hit, output swbs_pkg::result_t res);
    int iw, ih, ww, wh, c, r, k, wx, wy;
    logic [swbs_pkg::PIX_W-1:0] old;
    logic [swbs_pkg::SUM_W-1:0] ch [0:2];
    iw = clamp_to(int'(img_w_reg), STORE_W);
    ih = clamp_to(int'(img_h_reg), swbs_pkg::ROW_LIMIT);
    ww = clamp_to(int'(win_w_reg), 64);
    wh = clamp_to(int'(win_h_reg), 64);
    hit = 1'b0;
    res = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= iw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ih) row_pos = 0;
    c = col_pos;
    r = row_pos;
    ch[0] = 20'(px[7:0]);
    ch[1] = 20'(px[15:8]);
    ch[2] = 20'(px[23:16]);
    // column sums: add new pixel, drop the one wh rows up
    if (r == 0) begin
      for (k = 0; k < 3; k++) col_m[c][k] = ch[k];
    end else begin
      for (k = 0; k < 3; k++) col_m[c][k] += ch[k];
      if (r >= wh) begin
        old = rows_m[((r - wh) % STORE_H) * STORE_W + c];
        col_m[c][0] -= 20'(old[7:0]);
        col_m[c][1] -= 20'(old[15:8]);
        col_m[c][2] -= 20'(old[23:16]);
      end
    end
    rows_m[(r % STORE_H) * STORE_W + c] = px;
    // horizontal sum over the last ww columns
    if (c == 0) begin
      for (k = 0; k < 3; k++) horz_m[k] = col_m[c][k];
    end else begin
      for (k = 0; k < 3; k++) horz_m[k] += col_m[c][k];
      if (c >= ww)
        for (k = 0; k < 3; k++) horz_m[k] -= col_m[c - ww][k];
    end
    if (c + 1 >= ww && r + 1 >= wh) begin
      wx = c + 1 - ww;
      wy = r + 1 - wh;
      if (!align_reg || (wx % ww == 0 && wy % wh == 0)) begin
        hit = 1'b1;
        res.wx = wx[swbs_pkg::POS_W-1:0];
        res.wy = wy[swbs_pkg::POS_W-1:0];
        res.sums.red = horz_m[0];
        res.sums.green = horz_m[1];
        res.sums.blue = horz_m[2];
      end
    end
    col_pos = c + 1;
    if (col_pos >= iw) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= ih) row_pos = 0;
    end
  endtask

  // one register write transaction
  task automatic write_reg(input logic [swbs_pkg::IDX_W-1:0] idx,
                           input logic [swbs_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      swbs_pkg::REG_IMAGE_WIDTH:   img_w_reg = val;
      swbs_pkg::REG_IMAGE_HEIGHT:  img_h_reg = val;
      swbs_pkg::REG_WINDOW_WIDTH:  win_w_reg = val[swbs_pkg::WIN_W-1:0];
      swbs_pkg::REG_WINDOW_HEIGHT: win_h_reg = val[swbs_pkg::WIN_W-1:0];
      swbs_pkg::REG_ALIGNED_ONLY:  align_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int iw, input int ih, input int ww, input int wh,
                           input int al);
    write_reg(swbs_pkg::REG_IMAGE_WIDTH, 12'(iw));
    write_reg(swbs_pkg::REG_IMAGE_HEIGHT, 12'(ih));
    write_reg(swbs_pkg::REG_WINDOW_WIDTH, 12'(ww));
    write_reg(swbs_pkg::REG_WINDOW_HEIGHT, 12'(wh));
    write_reg(swbs_pkg::REG_ALIGNED_ONLY, 12'(al));
    cfg_valid <= 1'b0;
  endtask

  // drain every owed window, then let the pipeline settle
  task automatic drain;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // push one pixel; typed rows replace the model's window
  task automatic send_pixel(input logic [swbs_pkg::PIX_W-1:0] px, input bit fs,
                            input bit typed, input swbs_pkg::result_t want);
    int gap;
    bit hit;
    swbs_pkg::result_t res;
    gap = tx_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pixel <= px;
    frame_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    box_sum_step(px, fs, hit, res);
    if (typed) window_q.push_back(want);
    else if (hit) window_q.push_back(res);
  endtask

  function automatic logic [swbs_pkg::PIX_W-1:0] pick_pixel(input int mode);
    int roll;
    if (mode == 1) return 24'hFFFFFF;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 24'h000000;
    if (roll == 1) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  // one configuration phase of npix pixels
  task automatic run_phase(input int iw, input int ih, input int ww, input int wh,
                           input int al, input int npix, input bit lead_fs,
                           input int mode);
    int n;
    bit fs;
    drain();
    write_all(iw, ih, ww, wh, al);
    tx_eager = ($urandom_range(0, 3) == 0);
    rx_eager = ($urandom_range(0, 3) == 0);
    for (n = 0; n < npix; n++) begin
      fs = (n == 0) ? lead_fs : ($urandom_range(0, 39) == 0);
      send_pixel(pick_pixel(mode), fs, 1'b0, '0);
    end
    push <= 1'b0;
  endtask

  // result side: random pop stalls and scoring
  initial begin : score
    int stall;
    swbs_pkg::result_t want;
    bit bad;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (window_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected window x=%0d y=%0d", win_x, win_y);
      end else begin
        want = window_q.pop_front();
        bad = (win_x !== want.wx) || (win_y !== want.wy) ||
              (red_sum !== want.sums.red) || (green_sum !== want.sums.green) ||
              (blue_sum !== want.sums.blue);
        if (bad) begin
          err_count++;
          if (err_count <= 10)
            $display({"window mismatch: want x=%0d y=%0d r=%0d g=%0d b=%0d,",
                      " got x=%0d y=%0d r=%0d g=%0d b=%0d"},
                     want.wx, want.wy, want.sums.red, want.sums.green,
                     want.sums.blue, win_x, win_y, red_sum, green_sum, blue_sum);
        end
      end
    end
  end

  // stimulus
  initial begin : stim
    stim_row_t table_rows[$];
    stim_row_t row;
    swbs_pkg::result_t full_win;
    int i, k, iw, ih, ww, wh, frames, npix, wait_cycles;
    bit lead;
    push = 1'b0;
    pixel = '0;
    frame_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    random_pixels = 0;
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    col_pos = 0;
    row_pos = 0;
    img_w_reg = 12'd2048;
    img_h_reg = 12'd2048;
    win_w_reg = 7'd8;
    win_h_reg = 7'd8;
    align_reg = 1'b0;
    for (i = 0; i < STORE_W; i++)
      for (k = 0; k < 3; k++) col_m[i][k] = '0;
    for (k = 0; k < 3; k++) horz_m[k] = '0;
    for (i = 0; i < STORE_W * STORE_H; i++) rows_m[i] = '0;

    // reset
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 image, 2x2 window
    write_all(3, 3, 2, 2, 0);
    for (i = 0; i < 9; i++) begin
      row.px = 24'hFFFFFF;
      row.fs = (i == 0);
      row.typed = (i % 3 != 0) && (i >= 3);
      full_win.wx = 11'((i % 3) - 1);
      full_win.wy = 11'((i / 3) - 1);
      full_win.sums.red = 20'd1020;
      full_win.sums.green = 20'd1020;
      full_win.sums.blue = 20'd1020;
      row.want = full_win;
      table_rows.push_back(row);
    end
    // single channels and zero, wrapping into a new frame without a marker
    for (i = 0; i < 9; i++) begin
      case (i)
        0: row.px = 24'h000000;
        1: row.px = 24'h0000FF;
        2: row.px = 24'h00FF00;
        3: row.px = 24'hFF0000;
        4: row.px = 24'h000000;
        5: row.px = 24'hFFFFFF;
        6: row.px = 24'h010101;
        7: row.px = 24'h7F7F7F;
        default: row.px = 24'h808080;
      endcase
      row.fs = 1'b0;
      row.typed = 1'b0;
      table_rows.push_back(row);
    end
    // frame restart part way through a row
    for (i = 0; i < 5; i++) begin
      row.px = 24'(24'h00FF00 + i);
      row.fs = (i == 2);
      row.typed = 1'b0;
      table_rows.push_back(row);
    end
    foreach (table_rows[i])
      send_pixel(table_rows[i].px, table_rows[i].fs, table_rows[i].typed,
                 table_rows[i].want);
    push <= 1'b0;

    // widest window on one row, all channels at maximum
    run_phase(64, 2, 64, 1, 0, 128, 1'b1, 1);
    // tallest window on a one-column image, all channels at maximum
    run_phase(1, 64, 1, 64, 0, 70, 1'b1, 1);
    // widest row, oversized and zero window registers saturate
    run_phase(4095, 0, 127, 0, 1, 200, 1'b1, 0);
    // tall image register, partial frame only
    run_phase(5, 4095, 2, 3, 0, 40, 1'b1, 0);
    // single-row image entered without a marker: position wraps on shrink
    run_phase(4, 1, 1, 1, 0, 12, 1'b0, 0);

    // random frames
    while (random_pixels < 400) begin
      iw = $urandom_range(1, 24);
      ih = $urandom_range(1, 12);
      ww = $urandom_range(1, 9);
      wh = $urandom_range(1, 6);
      frames = $urandom_range(1, 3);
      npix = iw * ih * frames;
      if ($urandom_range(0, 9) == 0) ww = 0;
      if ($urandom_range(0, 9) == 0) wh = 0;
      if ($urandom_range(0, 9) == 0) ww = 64 + $urandom_range(0, 63);
      lead = (ih != 1) || $urandom_range(0, 1);
      if (npix > 300) npix = 300;
      run_phase(iw, ih, ww, wh, $urandom_range(0, 1), npix, lead, 0);
      random_pixels += npix;
    end

    // end of run
    wait_cycles = 0;
    while (window_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (window_q.size() != 0) err_count++;
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/swbs_pkg.sv
rtl/swbs_ram.sv
rtl/swbs_fifo.sv
rtl/swbs_front.sv
rtl/swbs_back.sv
rtl/sliding_window_rgb_box_sum.sv
tb/sliding_window_rgb_box_sum_tb.sv
